// ===== rtl/pate_pkg.sv =====
// Shared types and constants for the positional array table engine.
// No dependencies; imported by every module of the engine.
`default_nettype none

package pate_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned MAP_W   = 16;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND  = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_INSERT  = 3'd3,
		OP_DELETE  = 3'd4,
		OP_SEARCH  = 3'd5,
		OP_REPLACE = 3'd6,
		OP_READ    = 3'd7
	} req_op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// A classified request as it waits in the queue.
	typedef struct packed {
		req_op_t            op;
		logic [WORD_W-1:0]  value;
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   pos_idx;
		logic               pos_zero;
	} pate_req_t;

	// Outcome of one executed request, handed to the result stage.
	typedef struct packed {
		logic               valid;
		status_t            status;
		logic [CNT_W-1:0]   count;
		logic [WORD_W-1:0]  read_value;
	} pate_exec_t;

endpackage

`default_nettype wire

// ===== rtl/pate_front.sv =====
// Front part: takes requests, classifies them and holds them in a short queue.
// Depends on pate_pkg.
`default_nettype none

module pate_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [2:0]          req_type,
	input  wire logic signed [31:0]  value,
	input  wire logic [4:0]          position,
	output logic                     head_valid,
	output pate_pkg::pate_req_t      head
);
	import pate_pkg::*;

	pate_req_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	pate_req_t  incoming;
	logic       push;
	logic       pop;

	always_comb begin
		incoming.op       = req_op_t'(req_type);
		incoming.value    = value;
		incoming.pos      = position;
		incoming.pos_idx  = position - 5'd1;
		incoming.pos_zero = (position == '0);
	end

	assign busy       = (fill_q == 2'd2);
	assign push       = start && !busy;
	// The back part never stalls, so the head leaves in the cycle it shows.
	assign head_valid = (fill_q != 2'd0);
	assign pop        = head_valid;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pate_cells.sv =====
// Back part, first stage: the row of word cells, count and capacity registers.
// Shifts, writes, reads and compares all cells at once. Depends on pate_pkg.
`default_nettype none

module pate_cells #(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [4:0]          cfg_data,
	input  wire logic                head_valid,
	input  wire pate_pkg::pate_req_t head,
	output pate_pkg::pate_exec_t     exec_s1,
	output logic [DEPTH-1:0]         match_s1
);
	import pate_pkg::*;

	logic [WORD_W-1:0] elem_q [DEPTH];
	logic [WORD_W-1:0] elem_nxt [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  cap_eff;
	status_t           status;
	logic [WORD_W-1:0] rd_word;
	logic [DEPTH-1:0]  match;
	logic              ins_bad;
	logic              at_bad;
	logic              valid_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [WORD_W-1:0] read_value_s1;

	always_comb begin
		cap_eff = capacity_q;
		if (capacity_q == '0) begin
			cap_eff = 5'd1;
		end else if (int'(capacity_q) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end
	end

	// Insert may name one slot past the end; the others must name a held word.
	assign ins_bad = head.pos_zero || ({1'b0, head.pos} > ({1'b0, count_q} + 6'd1));
	assign at_bad  = head.pos_zero || (head.pos > count_q);

	always_comb begin
		elem_nxt  = elem_q;
		count_nxt = count_q;
		status    = ST_OK;
		rd_word   = '0;
		match     = '0;
		unique case (head.op)
			OP_CLEAR: begin
				count_nxt = '0;
			end
			OP_APPEND: begin
				if (count_q >= cap_eff) begin
					status = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (int'(count_q) == i) begin
							elem_nxt[i] = head.value;
						end
					end
					count_nxt = count_q + 5'd1;
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					count_nxt = count_q - 5'd1;
				end
			end
			OP_INSERT: begin
				if (ins_bad) begin
					status = ST_BADPOS;
				end else if (count_q >= cap_eff) begin
					status = ST_FULL;
				end else begin
					for (int i = 1; i < DEPTH; i++) begin
						if (i > int'(head.pos_idx)) begin
							elem_nxt[i] = elem_q[i-1];
						end
					end
					for (int i = 0; i < DEPTH; i++) begin
						if (i == int'(head.pos_idx)) begin
							elem_nxt[i] = head.value;
						end
					end
					count_nxt = count_q + 5'd1;
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < DEPTH; i++) begin
					match[i] = (i < int'(count_q)) && (elem_q[i] == head.value);
				end
			end
			OP_DELETE, OP_REPLACE, OP_READ: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (at_bad) begin
					status = ST_BADPOS;
				end else if (head.op == OP_DELETE) begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (i >= int'(head.pos_idx)) begin
							elem_nxt[i] = elem_q[i+1];
						end
					end
					count_nxt = count_q - 5'd1;
				end else if (head.op == OP_REPLACE) begin
					for (int i = 0; i < DEPTH; i++) begin
						if (i == int'(head.pos_idx)) begin
							elem_nxt[i] = head.value;
						end
					end
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (i == int'(head.pos_idx)) begin
							rd_word = elem_q[i];
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			capacity_q <= CAP_RESET;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (head_valid) begin
				count_q <= count_nxt;
			end
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (head_valid) begin
			elem_q        <= elem_nxt;
			status_s1     <= status;
			count_s1      <= count_nxt;
			read_value_s1 <= rd_word;
			match_s1      <= match;
		end
	end

	always_comb begin
		exec_s1.valid      = valid_s1;
		exec_s1.status     = status_s1;
		exec_s1.count      = count_s1;
		exec_s1.read_value = read_value_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/pate_result.sv =====
// Back part, second stage: reduces the match vector and drives the result ports.
// Depends on pate_pkg.
`default_nettype none

module pate_result #(
	parameter int DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pate_pkg::pate_exec_t exec_s1,
	input  wire logic [DEPTH-1:0]     match_s1,
	output logic                      done,
	output logic [1:0]                status,
	output logic [4:0]                count,
	output logic signed [31:0]        read_value,
	output logic                      found,
	output logic [4:0]                first_position,
	output logic [4:0]                occurrences,
	output logic [15:0]               match_map
);
	import pate_pkg::*;

	localparam int MW = (DEPTH < MAP_W) ? DEPTH : MAP_W;

	logic [POS_W-1:0] first;
	logic [CNT_W-1:0] occ;
	logic [MAP_W-1:0] map;

	// Matches only exist below the count, which stays under 32.
	always_comb begin
		first = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				first = POS_W'(i + 1);
			end
		end
		occ = CNT_W'($countones(match_s1));
		map = MAP_W'(match_s1[MW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= exec_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_s1.valid) begin
			status         <= exec_s1.status;
			count          <= exec_s1.count;
			read_value     <= exec_s1.read_value;
			found          <= |match_s1;
			first_position <= first;
			occurrences    <= occ;
			match_map      <= map;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/positional_array_table_engine_unit.sv =====
// Top level of the positional array table engine: front queue, cell row, result stage.
// Depends on pate_pkg, pate_front, pate_cells and pate_result.
//
//   Channel   Handshake          Payload
//   request   start / busy       req_type, value, position
//   result    done (one cycle)   status, count, read_value, found,
//                                first_position, occurrences, match_map
//   config    cfg_we             cfg_data (capacity)
//
// One request is taken per cycle; its result passes the queue entry, the cell-row
// registers and the result registers on its way to the ports.
// The cell row executes each request as soon as it reaches the head, so busy rises only if the
// two-entry queue fills, which the back part's steady draining prevents.
// Reset empties the table and sets the capacity to 16; no clearing pass is needed.
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none

module positional_array_table_engine_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] value,
	input  wire logic [4:0]         position,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_data,
	output logic                    done,
	output logic [1:0]              status,
	output logic [4:0]              count,
	output logic signed [31:0]      read_value,
	output logic                    found,
	output logic [4:0]              first_position,
	output logic [4:0]              occurrences,
	output logic [15:0]             match_map
);
	import pate_pkg::*;

	logic             head_valid;
	pate_req_t        head;
	pate_exec_t       exec_s1;
	logic [DEPTH-1:0] match_s1;

	pate_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.value      (value),
		.position   (position),
		.head_valid (head_valid),
		.head       (head)
	);

	pate_cells #(
		.DEPTH (DEPTH)
	) u_cells (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.exec_s1    (exec_s1),
		.match_s1   (match_s1)
	);

	pate_result #(
		.DEPTH (DEPTH)
	) u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.exec_s1        (exec_s1),
		.match_s1       (match_s1),
		.done           (done),
		.status         (status),
		.count          (count),
		.read_value     (read_value),
		.found          (found),
		.first_position (first_position),
		.occurrences    (occurrences),
		.match_map      (match_map)
	);

endmodule

`default_nettype wire
